// ===== hdl/lad_pkg.sv =====
// ============================================================================
// lad_pkg
// Shared sizes, request and status codes, and the command and status structs
// that join the deque controller to its datapath.
// ============================================================================
`default_nettype none

package lad_pkg;

    // Number of job slots in the array.
    localparam int MAX_JOBS = 64;

    // Index width: an index must also hold MAX_JOBS itself (one past the end).
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    // Slot address width.
    localparam int ADDR_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    // Fixed field widths of the ports.
    localparam int REQ_W  = 2;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 7;
    localparam int STS_W  = 2;
    localparam int OCC_W  = 7;

    // Width used to compare an index against the capacity register.
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INS_REAR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_REAR  = 2'd3;

    // Status codes.
    localparam logic [STS_W-1:0] STS_DONE    = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL    = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY   = 2'd2;
    localparam logic [STS_W-1:0] STS_BLOCKED = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;         // request word accepted this cycle
        logic load_direct;  // load the result register from the decode
        logic load_read;    // load the result register from the slot read
    } lad_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;      // the pending request is a delete that succeeds
    } lad_stat_t;

endpackage

`default_nettype wire

// ===== hdl/lad_ctrl.sv =====
// ============================================================================
// lad_ctrl
// Controller for the deque: request handshake, slot-read wait state and the
// result word valid flag.
// ============================================================================
`default_nettype none

module lad_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire lad_pkg::lad_stat_t stat,
    output lad_pkg::lad_cmd_t       cmd
);
    import lad_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The result register can take a new word when empty or being drained.
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.take       = in_valid && in_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.take)
                begin
                    if (stat.is_read)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        cmd.load_direct = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    cmd.load_read = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_direct || cmd.load_read)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A successful delete always enters the read state to wait for the slot read.
    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && stat.is_read) |=> (state_reg == ST_READ))
        else $error("delete did not enter the read state");

    // A waiting result word is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(cmd.load_direct || cmd.load_read))
        else $error("result word overwritten while stalled");

    // Any request that needs no slot read shows its result next cycle.
    a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && !stat.is_read) |=> out_valid_reg)
        else $error("direct result not presented");

endmodule

`default_nettype wire

// ===== hdl/lad_datapath.sv =====
// ============================================================================
// lad_datapath
// Datapath for the deque: front and rear indices, capacity register, job slot
// memories, request decode and the result word register.
// ============================================================================
`default_nettype none

module lad_datapath
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire lad_pkg::lad_cmd_t            cmd,
    output lad_pkg::lad_stat_t                stat,
    input  wire logic [lad_pkg::REQ_W-1:0]    req_type,
    input  wire logic [lad_pkg::DATA_W-1:0]   job_id,
    input  wire logic [lad_pkg::DATA_W-1:0]   job_time,
    input  wire logic                         cfg_valid,
    input  wire logic [lad_pkg::CAP_W-1:0]    cfg_data,
    output logic [lad_pkg::STS_W-1:0]         status,
    output logic [lad_pkg::DATA_W-1:0]        removed_id,
    output logic [lad_pkg::DATA_W-1:0]        removed_time,
    output logic [lad_pkg::OCC_W-1:0]         occupancy
);
    import lad_pkg::*;

    logic [CNT_W-1:0]  front_reg;
    logic [CNT_W-1:0]  front_next;
    logic [CNT_W-1:0]  rear_reg;
    logic [CNT_W-1:0]  rear_next;
    logic [CAP_W-1:0]  cap_reg;

    logic [DATA_W-1:0] id_mem   [MAX_JOBS];
    logic [DATA_W-1:0] time_mem [MAX_JOBS];
    logic [DATA_W-1:0] rd_id_reg;
    logic [DATA_W-1:0] rd_time_reg;
    logic [OCC_W-1:0]  occ_hold_reg;

    logic [STS_W-1:0]  status_reg;
    logic [DATA_W-1:0] id_reg;
    logic [DATA_W-1:0] time_reg;
    logic [OCC_W-1:0]  occ_reg;

    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  cap_eff;
    logic              is_empty;
    logic              rear_lt_cap;
    logic              front_nz;
    logic [CNT_W-1:0]  front_dec;
    logic [CNT_W-1:0]  rear_inc;
    logic [CNT_W-1:0]  rear_dec;
    logic [CNT_W-1:0]  front_inc;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [STS_W-1:0]  dec_status;
    logic [CNT_W-1:0]  occ_calc;
    logic [OCC_W-1:0]  dec_occ;

    assign cap_ext     = CMP_W'(cap_reg);
    assign cap_eff     = (cap_ext > CMP_W'(MAX_JOBS)) ? CMP_W'(MAX_JOBS) : cap_ext;
    assign is_empty    = (front_reg >= rear_reg);
    assign rear_lt_cap = (CMP_W'(rear_reg) < cap_eff);
    assign front_nz    = (front_reg != '0);
    assign front_dec   = front_reg - CNT_W'(1);
    assign front_inc   = front_reg + CNT_W'(1);
    assign rear_inc    = rear_reg + CNT_W'(1);
    assign rear_dec    = rear_reg - CNT_W'(1);

    // Request decode against the current indices.
    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = rear_reg[ADDR_W-1:0];
        rd_addr    = front_reg[ADDR_W-1:0];
        dec_status = STS_DONE;
        unique case (req_type)
            REQ_INS_FRONT:
            begin
                if (is_empty && rear_lt_cap)
                begin
                    wr_en     = 1'b1;
                    rear_next = rear_inc;
                end
                else if (front_nz)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = front_dec[ADDR_W-1:0];
                    front_next = front_dec;
                end
                else if (!rear_lt_cap)
                begin
                    dec_status = STS_FULL;
                end
                else
                begin
                    dec_status = STS_BLOCKED;
                end
            end
            REQ_INS_REAR:
            begin
                if (!rear_lt_cap)
                begin
                    dec_status = STS_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    rear_next = rear_inc;
                end
            end
            REQ_DEL_FRONT:
            begin
                if (is_empty)
                begin
                    dec_status = STS_EMPTY;
                end
                else
                begin
                    rd_en      = 1'b1;
                    front_next = front_inc;
                end
            end
            REQ_DEL_REAR:
            begin
                if (is_empty)
                begin
                    dec_status = STS_EMPTY;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = rear_dec[ADDR_W-1:0];
                    rear_next = rear_dec;
                end
            end
            default:
            begin
                dec_status = STS_DONE;
            end
        endcase
    end

    assign occ_calc     = (front_next >= rear_next) ? '0 : (rear_next - front_next);
    assign dec_occ      = OCC_W'(occ_calc);
    assign stat.is_read = rd_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            if (cmd.take)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
            end
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Job slots; a write and a read never fall in the same cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.take && wr_en)
        begin
            id_mem[wr_addr]   <= job_id;
            time_mem[wr_addr] <= job_time;
        end
        if (cmd.take && rd_en)
        begin
            rd_id_reg    <= id_mem[rd_addr];
            rd_time_reg  <= time_mem[rd_addr];
            occ_hold_reg <= dec_occ;
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_direct)
        begin
            status_reg <= dec_status;
            id_reg     <= '0;
            time_reg   <= '0;
            occ_reg    <= dec_occ;
        end
        else if (cmd.load_read)
        begin
            status_reg <= STS_DONE;
            id_reg     <= rd_id_reg;
            time_reg   <= rd_time_reg;
            occ_reg    <= occ_hold_reg;
        end
    end

    assign status       = status_reg;
    assign removed_id   = id_reg;
    assign removed_time = time_reg;
    assign occupancy    = occ_reg;

    // The array never wraps: the front never passes the rear.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg <= rear_reg)
        else $error("front index passed rear index");

    // The rear never runs past the end of the array.
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(rear_reg) <= CMP_W'(MAX_JOBS))
        else $error("rear index beyond array");

    // Indices move only when a request word is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.take |=> ($stable(front_reg) && $stable(rear_reg)))
        else $error("index changed without a request");

endmodule

`default_nettype wire

// ===== hdl/linear_array_deque.sv =====
// Result path: a request word that stores a job, fails or finds the queue empty
//   loads its result word straight from the decode; a successful delete first
//   passes through the registered slot read and the read state.
// Throughput: one request at a time; inserts and failed requests give one word
//   per cycle while out_ready holds; a successful delete stalls the next request.
// Reset: indices clear (queue empty), capacity returns to 64; slots are not cleared.
// ============================================================================
// linear_array_deque
// Double-ended job queue held in a linear array with a front index and a rear
// index, with a valid/ready request channel, result channel and capacity
// write channel.
// ============================================================================
`default_nettype none

module linear_array_deque
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    // Request channel.
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [lad_pkg::REQ_W-1:0]    req_type,
    input  wire logic [lad_pkg::DATA_W-1:0]   job_id,
    input  wire logic [lad_pkg::DATA_W-1:0]   job_time,

    // Result channel.
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [lad_pkg::STS_W-1:0]         status,
    output logic [lad_pkg::DATA_W-1:0]        removed_id,
    output logic [lad_pkg::DATA_W-1:0]        removed_time,
    output logic [lad_pkg::OCC_W-1:0]         occupancy,

    // Capacity write channel.
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [lad_pkg::CAP_W-1:0]    cfg_data
);
    import lad_pkg::*;

    lad_cmd_t  cmd;
    lad_stat_t stat;

    // The capacity register takes a write word in any cycle.
    assign cfg_ready = 1'b1;

    // The controller owns the handshakes and the wait for a slot read; the
    // result word register sits in the datapath, so a new request word can
    // be accepted in the same cycle the previous result word is taken.
    lad_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath decodes each request against the front and rear indices,
    // writes or reads at most one job slot and builds the result word.
    lad_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .job_id       (job_id),
        .job_time     (job_time),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .status       (status),
        .removed_id   (removed_id),
        .removed_time (removed_time),
        .occupancy    (occupancy)
    );

endmodule

`default_nettype wire
